// ----- rtl/core/pcftd_pkg.sv -----
// Shared types and constants for the page cache directory core.
package pcftd_pkg;

  // Directory geometry (power of two; queue positions wrap on the index width)
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Fixed field widths
  localparam int TEX_W    = 16;
  localparam int PAGE_W   = 32;
  localparam int BYTES_W  = 21;
  localparam int WORD_W   = 32;
  localparam int SLOT_W   = 6;
  localparam int REMOVE_W = 7;
  localparam int CFG_IDX_W = 1;

  // Opcodes
  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_EXPIRE = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME  = 1'd1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [TEX_W-1:0]   texture_id;
    logic [PAGE_W-1:0]  page_index;
    logic [BYTES_W-1:0] page_bytes;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [1:0]          status;
    logic [REMOVE_W-1:0] removed_count;
    logic [WORD_W-1:0]   total_bytes;
  } out_item_t;

  typedef struct packed {
    logic [TEX_W-1:0]   texture;
    logic [PAGE_W-1:0]  page;
    logic [BYTES_W-1:0] size;
    logic [WORD_W-1:0]  last_access;
  } entry_t;

endpackage

// ----- rtl/core/page_cache_fifo_ttl_directory_core.sv -----
// Page cache directory: key search, FIFO eviction under a byte budget, TTL expiry.
// Lookup scans the entry memory; remove scans, then compacts the queue; expire makes one
// pass over the queue; add scans, evicts from the queue head, then searches for a free
// slot. Tick and too-large add go straight to the result.
// One transaction at a time; the next is taken while the previous result waits to drain.
// Sequencing is set by the single-read-port entry memory and order-queue memory.
// Synchronous reset clears valid bits, counters and time and restores config defaults; memories are not cleared.
module page_cache_fifo_ttl_directory_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pcftd_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pcftd_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [pcftd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcftd_pkg::WORD_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_EV_CHK, S_EV_ORD, S_EV_DEC, S_FREE, S_PS_ORD, S_PS_DEC, S_FIN
  } state_t;

  state_t                             state;
  pcftd_pkg::in_item_t                req;
  pcftd_pkg::out_item_t               res;
  logic [pcftd_pkg::IDX_W:0]          scan_addr;
  logic [pcftd_pkg::IDX_W-1:0]        found_slot;
  logic [pcftd_pkg::IDX_W-1:0]        cur_slot;
  logic [pcftd_pkg::IDX_W-1:0]        head;
  logic [pcftd_pkg::CNT_W-1:0]        count;
  logic [pcftd_pkg::CNT_W-1:0]        rp;
  logic [pcftd_pkg::CNT_W-1:0]        wp;
  logic [pcftd_pkg::CNT_W-1:0]        removed;
  logic [pcftd_pkg::ENTRIES-1:0]      valid;
  logic [pcftd_pkg::WORD_W-1:0]       total;
  logic [pcftd_pkg::WORD_W-1:0]       time_now;
  logic [pcftd_pkg::WORD_W-1:0]       max_bytes;
  logic [pcftd_pkg::WORD_W-1:0]       lifetime;

  // Memories
  pcftd_pkg::entry_t                  ent_mem [pcftd_pkg::ENTRIES];
  logic [pcftd_pkg::IDX_W-1:0]        ord_mem [pcftd_pkg::ENTRIES];
  pcftd_pkg::entry_t                  ent_rdata;
  pcftd_pkg::entry_t                  ent_wdata;
  logic [pcftd_pkg::IDX_W-1:0]        ent_raddr;
  logic [pcftd_pkg::IDX_W-1:0]        ent_waddr;
  logic                               ent_we;
  logic [pcftd_pkg::IDX_W-1:0]        ord_rdata;
  logic [pcftd_pkg::IDX_W-1:0]        ord_wdata;
  logic [pcftd_pkg::IDX_W-1:0]        ord_raddr;
  logic [pcftd_pkg::IDX_W-1:0]        ord_waddr;
  logic                               ord_we;

  logic                               accept;
  logic                               too_large;
  logic [pcftd_pkg::IDX_W-1:0]        cmp_slot;
  logic [pcftd_pkg::IDX_W-1:0]        free_idx;
  logic                               match;
  logic                               over;
  logic                               need_evict;
  logic [pcftd_pkg::WORD_W-1:0]       age;
  logic                               drop_it;
  logic [pcftd_pkg::WORD_W-1:0]       total_drop;
  logic                               pass_last;
  logic [pcftd_pkg::CNT_W-1:0]        removed_inc;
  logic [pcftd_pkg::CNT_W-1:0]        wp_keep;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Datapath decodes
  assign too_large  = (in_data.opcode == pcftd_pkg::OP_ADD) &&
                      (pcftd_pkg::WORD_W'(in_data.page_bytes) > max_bytes);
  assign cmp_slot   = scan_addr[pcftd_pkg::IDX_W-1:0] - 1'b1;
  assign free_idx   = scan_addr[pcftd_pkg::IDX_W-1:0];
  assign match      = valid[cmp_slot] && (ent_rdata.texture == req.texture_id) &&
                      (ent_rdata.page == req.page_index);
  assign over       = ({1'b0, total} + 33'(req.page_bytes)) > {1'b0, max_bytes};
  assign need_evict = ((count != '0) && over) ||
                      (count == pcftd_pkg::CNT_W'(pcftd_pkg::ENTRIES));
  assign age        = time_now - ent_rdata.last_access;
  assign drop_it    = (req.opcode == pcftd_pkg::OP_REMOVE) ? (cur_slot == found_slot)
                                                           : (age >= lifetime);
  assign total_drop = total - pcftd_pkg::WORD_W'(ent_rdata.size);
  assign pass_last  = (rp + 1'b1) == count;
  assign removed_inc = removed + 1'b1;
  assign wp_keep    = wp + 1'b1;

  // Memory port control
  always_comb begin
    ent_raddr = '0;
    ent_waddr = cmp_slot;
    ent_wdata = ent_rdata;
    ent_we    = 1'b0;
    ord_raddr = head;
    ord_waddr = head + wp[pcftd_pkg::IDX_W-1:0];
    ord_wdata = cur_slot;
    ord_we    = 1'b0;
    unique case (state)
      S_SCAN: begin
        ent_raddr = scan_addr[pcftd_pkg::IDX_W-1:0];
        if (match && req.opcode == pcftd_pkg::OP_LOOKUP) begin
          ent_we                = 1'b1;
          ent_wdata.last_access = time_now;
        end
      end
      S_EV_ORD, S_PS_ORD: begin
        ent_raddr = ord_rdata;
      end
      S_PS_DEC: begin
        ord_raddr = head + rp[pcftd_pkg::IDX_W-1:0] + 1'b1;
        ord_we    = !drop_it;
      end
      S_FREE: begin
        ent_waddr = free_idx;
        ent_wdata = '{texture: req.texture_id, page: req.page_index,
                      size: req.page_bytes, last_access: time_now};
        ent_we    = !valid[free_idx];
        ord_waddr = head + count[pcftd_pkg::IDX_W-1:0];
        ord_wdata = free_idx;
        ord_we    = !valid[free_idx];
      end
      default: begin
      end
    endcase
  end

  // Entry and order memories, registered read
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rdata <= ord_mem[ord_raddr];
  end

  // Sequencer, directory state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      head      <= '0;
      count     <= '0;
      total     <= '0;
      time_now  <= '0;
      max_bytes <= 32'd67108864;
      lifetime  <= 32'd1000;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pcftd_pkg::CFG_MAX_BYTES) begin
          max_bytes <= cfg_data;
        end else begin
          lifetime <= cfg_data;
        end
      end
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req       <= in_data;
            scan_addr <= (pcftd_pkg::IDX_W+1)'(1);
            rp        <= '0;
            wp        <= '0;
            removed   <= '0;
            res       <= '{hit: 1'b0, slot: '0,
                           status: too_large ? pcftd_pkg::ST_TOO_LARGE : pcftd_pkg::ST_OK,
                           removed_count: '0, total_bytes: total};
            priority case (in_data.opcode)
              pcftd_pkg::OP_LOOKUP, pcftd_pkg::OP_REMOVE: begin
                state <= S_SCAN;
              end
              pcftd_pkg::OP_ADD: begin
                state <= too_large ? S_FIN : S_SCAN;
              end
              pcftd_pkg::OP_TICK: begin
                time_now <= time_now + 1'b1;
                state    <= S_FIN;
              end
              pcftd_pkg::OP_EXPIRE: begin
                state <= (count == '0) ? S_FIN : S_PS_ORD;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            found_slot <= cmp_slot;
            res.hit    <= 1'b1;
            res.slot   <= pcftd_pkg::SLOT_W'(cmp_slot);
            priority case (req.opcode)
              pcftd_pkg::OP_REMOVE: state <= S_PS_ORD;
              pcftd_pkg::OP_ADD: begin
                res.status <= pcftd_pkg::ST_DUPLICATE;
                state      <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end else if (scan_addr == (pcftd_pkg::IDX_W+1)'(pcftd_pkg::ENTRIES)) begin
            if (req.opcode == pcftd_pkg::OP_ADD) begin
              state <= S_EV_CHK;
            end else begin
              res.status <= pcftd_pkg::ST_NOT_FOUND;
              state      <= S_FIN;
            end
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        // Evict from the queue head until the page fits and a slot is spare
        S_EV_CHK: begin
          if (need_evict) begin
            state <= S_EV_ORD;
          end else begin
            scan_addr <= '0;
            state     <= S_FREE;
          end
        end
        S_EV_ORD: begin
          cur_slot <= ord_rdata;
          state    <= S_EV_DEC;
        end
        S_EV_DEC: begin
          total           <= total_drop;
          valid[cur_slot] <= 1'b0;
          head            <= head + 1'b1;
          count           <= count - 1'b1;
          removed         <= removed_inc;
          state           <= S_EV_CHK;
        end
        // Claim the lowest free slot and append it to the queue
        S_FREE: begin
          if (!valid[free_idx]) begin
            valid[free_idx]   <= 1'b1;
            count             <= count + 1'b1;
            total             <= total + pcftd_pkg::WORD_W'(req.page_bytes);
            res.hit           <= 1'b1;
            res.slot          <= pcftd_pkg::SLOT_W'(free_idx);
            res.removed_count <= pcftd_pkg::REMOVE_W'(removed);
            res.total_bytes   <= total + pcftd_pkg::WORD_W'(req.page_bytes);
            state             <= S_FIN;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        // Compaction pass over the queue: drop matching entries, pack the rest
        S_PS_ORD: begin
          cur_slot <= ord_rdata;
          state    <= S_PS_DEC;
        end
        S_PS_DEC: begin
          if (drop_it) begin
            total           <= total_drop;
            valid[cur_slot] <= 1'b0;
            removed         <= removed_inc;
          end else begin
            wp <= wp_keep;
          end
          if (pass_last) begin
            count           <= drop_it ? wp : wp_keep;
            res.total_bytes <= drop_it ? total_drop : total;
            if (req.opcode == pcftd_pkg::OP_EXPIRE) begin
              res.removed_count <= pcftd_pkg::REMOVE_W'(drop_it ? removed_inc : removed);
            end
            state <= S_FIN;
          end else begin
            rp    <= rp + 1'b1;
            state <= S_PS_ORD;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pcftd_pkg::CNT_W'(pcftd_pkg::ENTRIES))
    else $error("queue count exceeds table size");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(valid) == 32'(count)))
    else $error("valid bits disagree with queue count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer idle right after a transaction");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result issued outside the finish step");

endmodule

// ----- tb/page_cache_fifo_ttl_directory_checker.sv -----
// Checker for the page cache directory: watches both channels, predicts and compares results.
module page_cache_fifo_ttl_directory_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  pcftd_pkg::in_item_t                 in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  pcftd_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [pcftd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcftd_pkg::WORD_W-1:0]        cfg_data,
  output int                                  fail_count,
  output int                                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXP_DEPTH = 16;

  // Shadow copy of the directory
  logic [pcftd_pkg::WORD_W-1:0]  budget;
  logic [pcftd_pkg::WORD_W-1:0]  lifetime;
  logic                          dir_valid [pcftd_pkg::ENTRIES];
  logic [pcftd_pkg::TEX_W-1:0]   dir_tex [pcftd_pkg::ENTRIES];
  logic [pcftd_pkg::PAGE_W-1:0]  dir_page [pcftd_pkg::ENTRIES];
  logic [pcftd_pkg::BYTES_W-1:0] dir_size [pcftd_pkg::ENTRIES];
  logic [pcftd_pkg::WORD_W-1:0]  dir_seen [pcftd_pkg::ENTRIES];
  int                            order_q [pcftd_pkg::ENTRIES];
  int                            order_n;
  logic [pcftd_pkg::WORD_W-1:0]  bytes_held;
  logic [pcftd_pkg::WORD_W-1:0]  now_tick;

  // Expected results in arrival order
  pcftd_pkg::out_item_t exp_buf [EXP_DEPTH];
  int                   exp_rd;
  int                   exp_wr;
  int                   exp_n;

  assign pending_count = exp_n;

  function automatic int find_page(logic [pcftd_pkg::TEX_W-1:0] tex,
                                   logic [pcftd_pkg::PAGE_W-1:0] page);
    for (int i = 0; i < pcftd_pkg::ENTRIES; i++)
      if (dir_valid[i] && dir_tex[i] == tex && dir_page[i] == page) return i;
    return -1;
  endfunction

  // Remove queue position pos and free its slot
  function automatic void evict_at(int pos);
    int s;
    s = order_q[pos];
    bytes_held = bytes_held - pcftd_pkg::WORD_W'(dir_size[s]);
    dir_valid[s] = 1'b0;
    for (int k = pos; k + 1 < order_n; k++) order_q[k] = order_q[k + 1];
    order_n--;
  endfunction

  function automatic pcftd_pkg::out_item_t predict_directory(pcftd_pkg::in_item_t it);
    pcftd_pkg::out_item_t r;
    int f;
    int k;
    r = '0;
    case (it.opcode)
      pcftd_pkg::OP_LOOKUP, pcftd_pkg::OP_REMOVE: begin
        f = find_page(it.texture_id, it.page_index);
        if (f < 0) begin
          r.status = pcftd_pkg::ST_NOT_FOUND;
        end else begin
          r.hit = 1'b1;
          r.slot = pcftd_pkg::SLOT_W'(f);
          if (it.opcode == pcftd_pkg::OP_LOOKUP) dir_seen[f] = now_tick;
          else begin
            for (int p = 0; p < order_n; p++)
              if (order_q[p] == f) begin
                evict_at(p);
                break;
              end
          end
        end
      end
      pcftd_pkg::OP_ADD: begin
        f = find_page(it.texture_id, it.page_index);
        if (pcftd_pkg::WORD_W'(it.page_bytes) > budget) begin
          r.status = pcftd_pkg::ST_TOO_LARGE;
        end else if (f >= 0) begin
          r.hit = 1'b1;
          r.slot = pcftd_pkg::SLOT_W'(f);
          r.status = pcftd_pkg::ST_DUPLICATE;
        end else begin
          while (order_n > 0 &&
                 {1'b0, bytes_held} + 33'(it.page_bytes) > {1'b0, budget}) begin
            evict_at(0);
            r.removed_count++;
          end
          if (order_n >= pcftd_pkg::ENTRIES) begin
            evict_at(0);
            r.removed_count++;
          end
          for (k = 0; k < pcftd_pkg::ENTRIES; k++)
            if (!dir_valid[k]) break;
          dir_valid[k] = 1'b1;
          dir_tex[k] = it.texture_id;
          dir_page[k] = it.page_index;
          dir_size[k] = it.page_bytes;
          dir_seen[k] = now_tick;
          order_q[order_n] = k;
          order_n++;
          bytes_held = bytes_held + pcftd_pkg::WORD_W'(it.page_bytes);
          r.hit = 1'b1;
          r.slot = pcftd_pkg::SLOT_W'(k);
        end
      end
      pcftd_pkg::OP_TICK: now_tick = now_tick + 1;
      pcftd_pkg::OP_EXPIRE: begin
        k = 0;
        while (k < order_n) begin
          if (pcftd_pkg::WORD_W'(now_tick - dir_seen[order_q[k]]) >= lifetime) begin
            evict_at(k);
            r.removed_count++;
          end else begin
            k++;
          end
        end
      end
      default: ;
    endcase
    r.total_bytes = bytes_held;
    return r;
  endfunction

  // Track configuration, compare accepted output, predict on accepted input
  always @(posedge clk) begin
    pcftd_pkg::out_item_t want;
    int errs;
    errs = 0;
    if (rst) begin
      budget <= 32'd67108864;
      lifetime <= 32'd1000;
      for (int i = 0; i < pcftd_pkg::ENTRIES; i++) dir_valid[i] = 1'b0;
      order_n = 0;
      bytes_held = '0;
      now_tick = '0;
      exp_rd = 0;
      exp_wr = 0;
      exp_n = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pcftd_pkg::CFG_MAX_BYTES) budget <= cfg_data;
        else if (cfg_index == pcftd_pkg::CFG_LIFETIME) lifetime <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (exp_n == 0) begin
          $error("unexpected result transaction %p", out_data);
          errs++;
        end else begin
          want = exp_buf[exp_rd];
          exp_rd = (exp_rd + 1) % EXP_DEPTH;
          exp_n--;
          if (out_data.hit !== want.hit)
            $error("hit: expected %0d actual %0d", want.hit, out_data.hit);
          if (out_data.slot !== want.slot)
            $error("slot: expected %0d actual %0d", want.slot, out_data.slot);
          if (out_data.status !== want.status)
            $error("status: expected %0d actual %0d", want.status, out_data.status);
          if (out_data.removed_count !== want.removed_count)
            $error("removed_count: expected %0d actual %0d",
                   want.removed_count, out_data.removed_count);
          if (out_data.total_bytes !== want.total_bytes)
            $error("total_bytes: expected %0d actual %0d",
                   want.total_bytes, out_data.total_bytes);
          if (out_data !== want) errs++;
        end
      end
      if (in_valid && !in_stall) begin
        if (exp_n == EXP_DEPTH) begin
          $error("too many transactions awaiting results");
          errs++;
        end else begin
          exp_buf[exp_wr] = predict_directory(in_data);
          exp_wr = (exp_wr + 1) % EXP_DEPTH;
          exp_n++;
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- tb/page_cache_fifo_ttl_directory_core_test.sv -----
// Stimulus and verdict for the page cache directory core.
module page_cache_fifo_ttl_directory_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pcftd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pcftd_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [pcftd_pkg::CFG_IDX_W-1:0] cfg_index = pcftd_pkg::CFG_MAX_BYTES;
  logic [pcftd_pkg::WORD_W-1:0] cfg_data = '0;
  int fail_count;
  int pending_count;
  bit quiet_tail = 1'b0;

  // Small key pool so that lookups, duplicates and removes hit often
  logic [pcftd_pkg::TEX_W-1:0]  key_tex [8];
  logic [pcftd_pkg::PAGE_W-1:0] key_page [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  page_cache_fifo_ttl_directory_core u_top (.*);

  page_cache_fifo_ttl_directory_checker u_checker (.*);

  // Result side stalls in random bursts
  always @(posedge clk) begin
    int burst;
    if (rst || quiet_tail) begin
      out_stall <= 1'b0;
    end else if (burst > 0) begin
      burst--;
      if (burst == 0) out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(1, 15);
      out_stall <= 1'b1;
    end
  end

  // Present one transaction and hold it until taken
  task automatic send_item(logic [2:0] op, logic [pcftd_pkg::TEX_W-1:0] tex,
                           logic [pcftd_pkg::PAGE_W-1:0] page,
                           logic [pcftd_pkg::BYTES_W-1:0] nbytes);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, texture_id: tex, page_index: page, page_bytes: nbytes};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [pcftd_pkg::CFG_IDX_W-1:0] idx,
                           logic [pcftd_pkg::WORD_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    int sel;
    logic [2:0] op;
    logic [pcftd_pkg::BYTES_W-1:0] nbytes;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 7);
    if (pick < 35) op = pcftd_pkg::OP_ADD;
    else if (pick < 55) op = pcftd_pkg::OP_LOOKUP;
    else if (pick < 65) op = pcftd_pkg::OP_REMOVE;
    else if (pick < 85) op = pcftd_pkg::OP_TICK;
    else if (pick < 95) op = pcftd_pkg::OP_EXPIRE;
    else op = 3'($urandom_range(5, 7));
    case ($urandom_range(0, 3))
      0: nbytes = pcftd_pkg::BYTES_W'($urandom_range(0, 1048576));
      1: nbytes = pcftd_pkg::BYTES_W'($urandom);
      default: nbytes = pcftd_pkg::BYTES_W'($urandom_range(0, 4096));
    endcase
    if ($urandom_range(0, 4) == 0)
      send_item(op, pcftd_pkg::TEX_W'($urandom), $urandom, nbytes);
    else
      send_item(op, key_tex[sel], key_page[sel], nbytes);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      key_tex[i] = pcftd_pkg::TEX_W'($urandom);
      key_page[i] = $urandom;
    end
    key_tex[0] = '0;
    key_page[0] = '0;
    key_tex[1] = '1;
    key_page[1] = '1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, duplicates, misses, unused opcodes
    send_item(pcftd_pkg::OP_LOOKUP, key_tex[0], key_page[0], '0);
    send_item(pcftd_pkg::OP_ADD, key_tex[0], key_page[0], '0);
    send_item(pcftd_pkg::OP_ADD, key_tex[1], key_page[1], pcftd_pkg::BYTES_W'(1048576));
    send_item(pcftd_pkg::OP_ADD, key_tex[1], key_page[1], 21'd5);
    send_item(pcftd_pkg::OP_ADD, key_tex[2], key_page[2], '1);
    send_item(pcftd_pkg::OP_LOOKUP, key_tex[1], key_page[1], '0);
    send_item(pcftd_pkg::OP_REMOVE, key_tex[0], key_page[0], '0);
    send_item(pcftd_pkg::OP_REMOVE, key_tex[0], key_page[0], '0);
    send_item(pcftd_pkg::OP_TICK, '1, '1, '1);
    send_item(3'd5, '0, '0, '0);
    send_item(3'd6, '1, '1, '1);
    send_item(3'd7, '0, '0, '0);
    send_item(pcftd_pkg::OP_EXPIRE, '0, '0, '0);
    drain_results();

    // Tiny budget: oversize rejection, zero-byte pages fit, budget evictions
    write_reg(pcftd_pkg::CFG_MAX_BYTES, 32'd1);
    write_reg(pcftd_pkg::CFG_LIFETIME, 32'd1);
    send_item(pcftd_pkg::OP_ADD, 16'h1234, 32'h1, 21'd2);
    send_item(pcftd_pkg::OP_ADD, 16'h1234, 32'h2, 21'd0);
    send_item(pcftd_pkg::OP_ADD, 16'h1234, 32'h3, 21'd1);
    send_item(pcftd_pkg::OP_ADD, 16'h1234, 32'h4, 21'd1);
    send_item(pcftd_pkg::OP_TICK, '0, '0, '0);
    send_item(pcftd_pkg::OP_EXPIRE, '0, '0, '0);
    drain_results();

    // Zero lifetime and max budget: fill past the table size, expire all
    write_reg(pcftd_pkg::CFG_MAX_BYTES, '1);
    write_reg(pcftd_pkg::CFG_LIFETIME, 32'd0);
    for (int i = 0; i < 70; i++)
      send_item(pcftd_pkg::OP_ADD, 16'hbeef, 32'(i), 21'd1000);
    send_item(pcftd_pkg::OP_EXPIRE, '0, '0, '0);
    drain_results();

    // Random phases across several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(pcftd_pkg::CFG_MAX_BYTES, 32'd67108864);
          write_reg(pcftd_pkg::CFG_LIFETIME, 32'd3);
        end
        1: begin
          write_reg(pcftd_pkg::CFG_MAX_BYTES, 32'd3000000);
          write_reg(pcftd_pkg::CFG_LIFETIME, 32'd10);
        end
        2: begin
          write_reg(pcftd_pkg::CFG_MAX_BYTES, 32'd8000);
          write_reg(pcftd_pkg::CFG_LIFETIME, 32'd1);
        end
        3: begin
          write_reg(pcftd_pkg::CFG_MAX_BYTES, '1);
          write_reg(pcftd_pkg::CFG_LIFETIME, '1);
        end
        4: begin
          write_reg(pcftd_pkg::CFG_MAX_BYTES, $urandom);
          write_reg(pcftd_pkg::CFG_LIFETIME, $urandom_range(1, 20));
        end
        default: begin
          write_reg(pcftd_pkg::CFG_MAX_BYTES, 32'd2000000);
          write_reg(pcftd_pkg::CFG_LIFETIME, 32'd5);
          quiet_tail = 1'b1;
        end
      endcase
      for (int n = 0; n < 100; n++) random_item();
      drain_results();
    end

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pcftd_pkg.sv
rtl/core/page_cache_fifo_ttl_directory_core.sv
tb/page_cache_fifo_ttl_directory_checker.sv
tb/page_cache_fifo_ttl_directory_core_test.sv
